// File: hdl/gray_gradient_edge_points_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gray gradient edge point block
// Concurrent checks on i_clk, switched off when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef GRAY_GRADIENT_EDGE_POINTS_ASSERT_SVH
`define GRAY_GRADIENT_EDGE_POINTS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cond in this cycle implies prop in the same cycle
`define GGEP_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("gray_gradient_edge_points: same-cycle check failed");

// cond in this cycle implies prop in the next cycle
`define GGEP_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("gray_gradient_edge_points: next-cycle check failed");

`else

`define GGEP_ASSERT_IMP(label, cond, prop)
`define GGEP_ASSERT_NXT(label, cond, prop)

`endif

`endif

// File: hdl/ggep_pkg.sv
// ---------------------------------------------------------------------------
// ggep_pkg
// Constants, types and arithmetic helpers of the gray gradient edge block.
// ---------------------------------------------------------------------------
`default_nettype none

package ggep_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 3;

    // column / row counters and line buffer address
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    // clamped dimensions must hold MAX_WIDTH / MAX_HEIGHT themselves
    localparam int WEFF_W = COL_W + 1;
    localparam int HEFF_W = ROW_W + 1;

    localparam int PIX_W      = 8;
    localparam int THR_W      = 9;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int MAG_W      = SQ_W + 1;
    localparam int THR_SQ_W   = 19;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

    localparam logic [THR_W-1:0]    THR_RESET    = 9'd30;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // floor(s/3) == (s*683) >> 11 for every s up to 765
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    typedef logic [PIX_W-1:0]    t_pix;
    typedef logic [COL_W-1:0]    t_col;
    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [SQ_W-1:0]     t_sq;
    typedef logic [THR_SQ_W-1:0] t_thr_sq;

    // (t+1)^2, the smallest squared magnitude that counts as an edge
    function automatic t_thr_sq thr_square(input logic [THR_W-1:0] t);
        logic [THR_W:0]       t1;
        logic [2*THR_W+1:0]   p;
        t1 = {1'b0, t} + (THR_W+1)'(1);
        p  = t1 * t1;
        return p[THR_SQ_W-1:0];
    endfunction

    // integer mean of the three color components
    function automatic t_pix gray_of(input t_pix b, input t_pix g, input t_pix r);
        logic [9:0]  s;
        logic [19:0] p;
        s = {2'b00, b} + {2'b00, g} + {2'b00, r};
        p = s * DIV3_MUL;
        return p[DIV3_SHIFT+PIX_W-1:DIV3_SHIFT];
    endfunction

    // square of |a - b|
    function automatic t_sq abs_diff_sq(input t_pix a, input t_pix b);
        t_pix d;
        d = (a >= b) ? (a - b) : (b - a);
        return d * d;
    endfunction

endpackage

`default_nettype wire

// File: hdl/gray_gradient_edge_points.sv
// ---------------------------------------------------------------------------
// gray_gradient_edge_points
// Gray conversion, two line buffers and a central difference gradient test;
// emits the coordinates of every interior pixel whose magnitude exceeds the
// threshold, in raster order.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  pixel in | i_in_valid / o_in_stall | i_blue, i_green, i_red
//  edge out | o_out_valid/ i_out_stall| o_feature_x, o_feature_y
//  config   | i_cfg_we                | i_cfg_index, i_cfg_data
//
//  One pixel per clock while o_in_stall is low: each line buffer takes one
//  write and two reads per pixel. A feature passes stage A, stage B and the
//  output register after the pixel one row and one column past it is taken.
//  Reset loads the register defaults and clears counters and stage valids;
//  the line buffers are left as they are and need no clearing pass.
//  o_in_stall rises only when an output stall has filled all three stages.
// ---------------------------------------------------------------------------
`default_nettype none

module gray_gradient_edge_points (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel transactions
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ggep_pkg::PIX_W-1:0]          i_blue,
    input  logic [ggep_pkg::PIX_W-1:0]          i_green,
    input  logic [ggep_pkg::PIX_W-1:0]          i_red,
    // feature transactions
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ggep_pkg::COL_W-1:0]          o_feature_x,
    output logic [ggep_pkg::ROW_W-1:0]          o_feature_y,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [ggep_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ggep_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

`include "gray_gradient_edge_points_assert.svh"

    localparam int COL_W  = ggep_pkg::COL_W;
    localparam int ROW_W  = ggep_pkg::ROW_W;
    localparam int WEFF_W = ggep_pkg::WEFF_W;
    localparam int HEFF_W = ggep_pkg::HEFF_W;
    localparam int MAG_W  = ggep_pkg::MAG_W;
    localparam int THR_SQ_W = ggep_pkg::THR_SQ_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    ggep_pkg::t_thr_sq                 r_thr_sq;   // (threshold+1)^2
    logic [ggep_pkg::WIDTH_W-1:0]      r_width;
    logic [ggep_pkg::HEIGHT_W-1:0]     r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq <= ggep_pkg::thr_square(ggep_pkg::THR_RESET);
            r_width  <= ggep_pkg::WIDTH_RESET;
            r_height <= ggep_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ggep_pkg::REG_EDGE_THRESHOLD: begin
                    r_thr_sq <= ggep_pkg::thr_square(i_cfg_data[ggep_pkg::THR_W-1:0]);
                end
                ggep_pkg::REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[ggep_pkg::WIDTH_W-1:0];
                end
                ggep_pkg::REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[ggep_pkg::HEIGHT_W-1:0];
                end
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    // clamp the dimensions to [3, MAX]
    logic [WEFF_W-1:0] w_eff;
    logic [HEFF_W-1:0] h_eff;

    always_comb begin
        if (r_width < WEFF_W'(ggep_pkg::MIN_DIM)) begin
            w_eff = WEFF_W'(ggep_pkg::MIN_DIM);
        end else if (r_width > WEFF_W'(ggep_pkg::MAX_WIDTH)) begin
            w_eff = WEFF_W'(ggep_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height < HEFF_W'(ggep_pkg::MIN_DIM)) begin
            h_eff = HEFF_W'(ggep_pkg::MIN_DIM);
        end else if (r_height > HEFF_W'(ggep_pkg::MAX_HEIGHT)) begin
            h_eff = HEFF_W'(ggep_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // ------------------------------------------------------------------
    // handshake: three stages, each advances when the next has room
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_o_valid;
    logic ready_o, ready_b, ready_a;
    logic accept_in;

    assign ready_o    = !r_o_valid || !i_out_stall;
    assign ready_b    = !r_b_valid || ready_o;
    assign ready_a    = !r_a_valid || ready_b;
    assign o_in_stall = !ready_a;
    assign accept_in  = i_in_valid && ready_a;

    // ------------------------------------------------------------------
    // raster position of the incoming pixel
    // ------------------------------------------------------------------
    ggep_pkg::t_col r_col, n_col, x_cur, addr_xm1, addr_xm2;
    ggep_pkg::t_row r_row, n_row, y_cur;
    logic           interior;

    always_comb begin
        // counters left beyond a shrunken image fall on its last column / row
        x_cur = ({1'b0, r_col} >= w_eff) ? COL_W'(w_eff - WEFF_W'(1)) : r_col;
        y_cur = ({1'b0, r_row} >= h_eff) ? ROW_W'(h_eff - HEFF_W'(1)) : r_row;
        addr_xm1 = x_cur - COL_W'(1);
        addr_xm2 = x_cur - COL_W'(2);
        interior = (x_cur >= COL_W'(2)) && (y_cur >= ROW_W'(2));

        if (({1'b0, x_cur} + WEFF_W'(1)) >= w_eff) begin
            n_col = '0;
            n_row = (({1'b0, y_cur} + HEFF_W'(1)) >= h_eff) ? '0 : y_cur + ROW_W'(1);
        end else begin
            n_col = x_cur + COL_W'(1);
            n_row = y_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept_in) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // line buffers
    // newer row takes the gray value on accept; older row takes the newer
    // row's old value in the following cycle, once that read has come back.
    // ------------------------------------------------------------------
    ggep_pkg::t_pix gray;
    assign gray = ggep_pkg::gray_of(i_blue, i_green, i_red);

    ggep_pkg::t_pix r_newer_mem [ggep_pkg::MAX_WIDTH];
    ggep_pkg::t_pix r_older_mem [ggep_pkg::MAX_WIDTH];

    ggep_pkg::t_pix r_a_newer_x;    // row y-1, column x   (right)
    ggep_pkg::t_pix r_a_newer_xm1;  // row y,   column x-1 (below)
    ggep_pkg::t_pix r_a_older_x;    // row y-2, column x   (above, next pixel)
    ggep_pkg::t_pix r_a_older_xm2;  // row y-1, column x-2 (left)
    ggep_pkg::t_pix r_above;        // row y-2, column x-1
    ggep_pkg::t_col r_a_x;
    ggep_pkg::t_row r_a_y;
    logic           r_a_interior;
    logic           r_wb_en;

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_newer_mem[x_cur] <= gray;
            r_a_newer_x        <= r_newer_mem[x_cur];
            r_a_newer_xm1      <= r_newer_mem[addr_xm1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wb_en) begin
            r_older_mem[r_a_x] <= r_a_newer_x;
        end
        if (accept_in) begin
            r_a_older_x   <= r_older_mem[x_cur];
            r_a_older_xm2 <= r_older_mem[addr_xm2];
        end
    end

    // stage A: read data plus position
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_above      <= r_a_older_x;   // read of the previous pixel
            r_a_x        <= x_cur;
            r_a_y        <= y_cur;
            r_a_interior <= interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_wb_en   <= 1'b0;
        end else begin
            r_wb_en <= accept_in;
            if (accept_in) begin
                r_a_valid <= 1'b1;
            end else if (ready_b) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage B: squared central differences, coordinates of the center
    // ------------------------------------------------------------------
    ggep_pkg::t_sq  r_b_gx2, r_b_gy2;
    ggep_pkg::t_col r_b_x;
    ggep_pkg::t_row r_b_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            // border pixels only update the buffers and drop out here
            r_b_valid <= r_a_valid && r_a_interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_a_valid) begin
            r_b_gx2 <= ggep_pkg::abs_diff_sq(r_a_newer_x, r_a_older_xm2);
            r_b_gy2 <= ggep_pkg::abs_diff_sq(r_a_newer_xm1, r_above);
            r_b_x   <= r_a_x - COL_W'(1);
            r_b_y   <= r_a_y - ROW_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // output register: magnitude test
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag2;
    logic             is_edge;
    ggep_pkg::t_col   r_o_x;
    ggep_pkg::t_row   r_o_y;

    assign mag2    = {1'b0, r_b_gx2} + {1'b0, r_b_gy2};
    assign is_edge = THR_SQ_W'(mag2) >= r_thr_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ready_o) begin
            r_o_valid <= r_b_valid && is_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_o && r_b_valid) begin
            r_o_x <= r_b_x;
            r_o_y <= r_b_y;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_feature_x = r_o_x;
    assign o_feature_y = r_o_y;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a stalled input means every stage is occupied
    `GGEP_ASSERT_IMP(a_stall_full, o_in_stall, r_a_valid && r_b_valid && r_o_valid)
    // features are never on the image border row or column zero
    `GGEP_ASSERT_IMP(a_feature_interior, r_o_valid, (r_o_x != '0) && (r_o_y != '0))
    // column counter wraps inside the clamped width
    `GGEP_ASSERT_NXT(a_col_in_range, accept_in && !i_cfg_we, {1'b0, r_col} < w_eff)

endmodule

`default_nettype wire
